// ===== rtl/rhe_pkg.sv =====
// Shared types and constants for the RGB histogram equaliser.
// No dependencies; used by every module in rtl/.
package rhe_pkg;

    localparam int unsigned CfgBits  = 24;
    localparam int unsigned PixBits  = 8;
    localparam int unsigned ModeBits = 3;
    localparam int unsigned Lanes    = 3;
    localparam int unsigned DivSteps = 9;

    typedef enum logic [ModeBits-1:0] {
        MODE_CLEAR = 3'd0,
        MODE_COUNT = 3'd1,
        MODE_BUILD = 3'd2,
        MODE_MAP   = 3'd3,
        MODE_PASS  = 3'd4
    } t_mode;

    // Lane controls issued by the sequencer, one group per cycle.
    typedef struct packed {
        logic clr;
        logic cnt;
        logic acc;
        logic rd;
    } t_lane_ctl;

endpackage

// ===== rtl/rhe_lane.sv =====
// One colour channel: histogram memory, in-place cumulative build and read port.
// Depends on rhe_pkg.
module rhe_lane #(
    parameter int unsigned BINS       = 256,
    parameter int unsigned COUNT_BITS = 24,
    parameter int unsigned AW         = 8
) (
    input  logic                         i_clk,
    input  rhe_pkg::t_lane_ctl           i_ctl,
    input  logic [AW-1:0]                i_addr,
    input  logic [rhe_pkg::PixBits-1:0]  i_pix,
    output logic [COUNT_BITS-1:0]        o_rdata
);
    localparam logic [COUNT_BITS-1:0] CntMax = '1;

    logic [COUNT_BITS-1:0] r_mem [BINS];
    logic [COUNT_BITS-1:0] r_sum;
    logic [COUNT_BITS-1:0] r_rdata;
    logic [AW-1:0]         w_bin;
    logic [COUNT_BITS:0]   w_add;

    // Clamp channel value to the last bin
    always_comb begin
        if ({1'b0, i_pix} >= (rhe_pkg::PixBits+1)'(BINS))
            w_bin = AW'(BINS - 1);
        else
            w_bin = AW'(i_pix);
    end

    assign w_add = {1'b0, r_sum} + {1'b0, r_rdata};

    // Read-modify-write pipeline: read one cycle, write the next.
    // The running sum is zeroed by the clear sweep, updated by accumulate writes and held otherwise.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_ctl.rd ? w_bin : i_addr];
        if (i_ctl.clr) begin
            r_mem[i_addr] <= '0;
            r_sum         <= '0;
        end else if (i_ctl.cnt) begin
            if (r_rdata != CntMax)
                r_mem[i_addr] <= r_rdata + 1'b1;
        end else if (i_ctl.acc) begin
            // saturate the running sum
            if (w_add[COUNT_BITS]) begin
                r_sum         <= CntMax;
                r_mem[i_addr] <= CntMax;
            end else begin
                r_sum         <= w_add[COUNT_BITS-1:0];
                r_mem[i_addr] <= w_add[COUNT_BITS-1:0];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rhe_divider.sv =====
// Restoring divider: floor(cum*256/div) saturated at 255, one quotient bit a cycle.
// Depends on rhe_pkg.
module rhe_divider #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [COUNT_BITS-1:0]        i_num,
    input  logic [rhe_pkg::CfgBits-1:0]  i_div,
    output logic                         o_done,
    output logic [rhe_pkg::PixBits-1:0]  o_quo
);
    localparam int unsigned RW = rhe_pkg::CfgBits + 2;
    localparam int unsigned NW = COUNT_BITS + rhe_pkg::PixBits;
    localparam int unsigned CW = $clog2(NW);

    logic [NW-1:0] r_num, n_num;
    logic [RW-1:0] r_rem, n_rem;
    logic [rhe_pkg::DivSteps-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_done, n_done;
    logic [rhe_pkg::CfgBits-1:0] r_div;
    logic [RW-1:0] w_sh;

    // Only the low nine bits of the NW-bit quotient are kept; a one in any bit above
    // the ninth forces saturation, caught by checking the step count when a bit is set.
    assign w_sh = {r_rem[RW-2:0], r_num[NW-1]};

    always_comb begin
        n_num  = r_num;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_go) begin
            n_num  = {i_num, {rhe_pkg::PixBits{1'b0}}};
            n_rem  = '0;
            n_quo  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = {r_num[NW-2:0], 1'b0};
            if (w_sh >= {2'b00, r_div}) begin
                n_rem = w_sh - {2'b00, r_div};
                n_quo = {r_quo[rhe_pkg::DivSteps-2:0], 1'b1};
                // quotient bit above bit 8 means saturation
                if (r_cnt < CW'(NW - rhe_pkg::DivSteps))
                    n_quo = '1;
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[rhe_pkg::DivSteps-2:0], 1'b0};
                if (r_quo == '1 && r_cnt != '0) n_quo = '1;
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        if (i_go) r_div <= (i_div == '0) ? rhe_pkg::CfgBits'(1) : i_div;
        r_num <= n_num;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = (r_quo[rhe_pkg::DivSteps-1]) ? '1 : r_quo[rhe_pkg::PixBits-1:0];
endmodule

// ===== rtl/rgb_histogram_equalizer.sv =====
// Top level of the RGB histogram equaliser: sequencer, three lanes, merge.
// Depends on rhe_pkg, rhe_lane, rhe_divider.
//
// Usage: raise start with i_mode and a pixel while busy is low; the item
// transfers at that edge. Clear sweeps all bins with busy high; count is busy
// for a read and an update; build is busy while it reads and writes back each
// bin, and is skipped once built; map is busy for one bin read, one divider
// load, COUNT_BITS+8 bit-serial divider steps and the result cycle, so the
// result shows in the last busy cycle. Pass gives its result in the cycle
// after the transfer and does not raise busy, so items may follow back to back.
// Map and pass give one result on o_red_out/o_green_out/o_blue_out,
// marked by o_valid for one cycle; the receiver cannot stall.
// i_cfg_we writes total_pixels (0 treated as 1); write it while idle.
// After reset the block sweeps all bins to zero with busy high; configuration
// writes are taken throughout.
module rgb_histogram_equalizer #(
    parameter int unsigned BINS       = 256,
    parameter int unsigned COUNT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_mode,
    input  logic [7:0]                   i_red_in,
    input  logic [7:0]                   i_green_in,
    input  logic [7:0]                   i_blue_in,
    input  logic                         i_cfg_we,
    input  logic [23:0]                  i_cfg_data,
    output logic                         o_valid,
    output logic [7:0]                   o_red_out,
    output logic [7:0]                   o_green_out,
    output logic [7:0]                   o_blue_out
);
    localparam int unsigned AW = (BINS > 1) ? $clog2(BINS) : 1;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_CRD  = 7'b0000100,
        S_CWR  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_MRD  = 7'b0100000,
        S_DIV  = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [AW:0]  r_addr, n_addr;
    logic         r_built, n_built;
    logic [23:0]  r_tot;
    logic [7:0]   r_pix [rhe_pkg::Lanes];
    logic         r_pass;
    logic         r_go;
    rhe_pkg::t_lane_ctl w_ctl;
    logic [COUNT_BITS-1:0] w_rd [rhe_pkg::Lanes];
    logic [rhe_pkg::Lanes-1:0] w_done;
    logic [7:0]   w_q [rhe_pkg::Lanes];
    logic         w_last;

    assign w_last   = (r_addr == (AW+1)'(BINS - 1));
    assign busy     = (r_st != S_IDLE);

    // Sequencer
    always_comb begin
        n_st    = r_st;
        n_addr  = r_addr;
        n_built = r_built;
        w_ctl   = '0;
        unique case (r_st)
            S_CLR: begin
                w_ctl.clr = 1'b1;
                n_addr    = r_addr + 1'b1;
                if (w_last) n_st = S_IDLE;
            end
            S_IDLE: begin
                n_addr = '0;
                if (start) begin
                    unique case (i_mode)
                        rhe_pkg::MODE_CLEAR: begin
                            n_st = S_CLR;
                            n_built = 1'b0;
                        end
                        rhe_pkg::MODE_COUNT: n_st = S_CRD;
                        rhe_pkg::MODE_BUILD: if (!r_built) n_st = S_ACC;
                        rhe_pkg::MODE_MAP:   n_st = S_MRD;
                        default: ;
                    endcase
                end
            end
            S_CRD: begin
                w_ctl.rd = 1'b1;
                n_st     = S_CWR;
            end
            S_CWR: begin
                w_ctl.cnt = 1'b1;
                n_st      = S_IDLE;
            end
            S_ACC: begin
                // odd phase writes the bin read in the even phase
                if (r_addr[0]) begin
                    w_ctl.acc = 1'b1;
                    n_addr    = r_addr + 1'b1;
                    if (r_addr[AW:1] == AW'(BINS - 1)) begin
                        n_st    = S_IDLE;
                        n_built = 1'b1;
                    end
                end else begin
                    w_ctl.acc = 1'b0;
                    n_addr    = r_addr + 1'b1;
                end
            end
            S_MRD: begin
                // read the bin of each channel for the divider
                w_ctl.rd = 1'b1;
                n_st     = S_DIV;
            end
            S_DIV: if (w_done[0]) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // Keep the sum across read phases in the lane: acc high only in the odd write phase
    logic [AW-1:0] w_laddr;
    rhe_pkg::t_lane_ctl w_lctl;
    always_comb begin
        w_lctl = w_ctl;
        w_laddr = r_addr[AW-1:0];
        if (r_st == S_ACC) begin
            w_laddr = r_addr[AW:1];
            w_lctl.acc = r_addr[0];
            w_lctl.clr = (r_addr == '0) ? 1'b0 : 1'b0;
        end
        if (r_st == S_CRD || r_st == S_CWR || r_st == S_MRD) w_laddr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_CLR;
            r_addr  <= '0;
            r_built <= 1'b0;
            r_tot   <= 24'd1;
            r_pass  <= 1'b0;
            r_go    <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_addr  <= n_addr;
            r_built <= n_built;
            r_pass  <= start && !busy && (i_mode == rhe_pkg::MODE_PASS);
            r_go    <= (r_st == S_MRD);
            if (i_cfg_we) r_tot <= i_cfg_data;
        end
        if (start && !busy) begin
            r_pix[0] <= i_red_in;
            r_pix[1] <= i_green_in;
            r_pix[2] <= i_blue_in;
        end
    end

    // Lanes and dividers
    for (genvar g = 0; g < rhe_pkg::Lanes; g++) begin : g_lane
        logic [AW-1:0] w_cbin;
        always_comb begin
            if ({1'b0, r_pix[g]} >= 9'(BINS)) w_cbin = AW'(BINS - 1);
            else                              w_cbin = AW'(r_pix[g]);
        end
        rhe_lane #(.BINS(BINS), .COUNT_BITS(COUNT_BITS), .AW(AW)) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_lctl),
            .i_addr  ((r_st == S_CWR) ? w_cbin : w_laddr),
            .i_pix   (r_pix[g]),
            .o_rdata (w_rd[g])
        );
        rhe_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (r_go),
            .i_num   (w_rd[g]),
            .i_div   (r_tot),
            .o_done  (w_done[g]),
            .o_quo   (w_q[g])
        );
    end

    // Merge lane results
    always_comb begin
        o_valid     = r_pass || w_done[0];
        o_red_out   = r_pass ? r_pix[0] : w_q[0];
        o_green_out = r_pass ? r_pix[1] : w_q[1];
        o_blue_out  = r_pass ? r_pix[2] : w_q[2];
    end

    a_done_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[0] |-> w_done[1] && w_done[2]) else $error("lanes out of step");
    a_no_pass_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pass && w_done[0])) else $error("result collision");
    a_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[0] |=> r_st == S_IDLE) else $error("divider done outside map");
endmodule
